// File: rtl/mca_pkg.sv
// Shared types and widths for the min-cost assignment solver.
`timescale 1ns / 1ps

package mca_pkg;
    localparam int MAX_N = 16;
    localparam int COST_WIDTH = 16;
    localparam int SIZE_WIDTH = 5;
    localparam int IDX_WIDTH = $clog2(MAX_N);
    localparam int TOTAL_WIDTH = 24;

    typedef struct packed {
        logic signed [COST_WIDTH-1:0] cost_value;
    } cost_item_t;

    typedef struct packed {
        logic [IDX_WIDTH-1:0]          agent_index;
        logic [IDX_WIDTH-1:0]          assigned_task;
        logic signed [TOTAL_WIDTH-1:0] total_cost;
        logic                          last_result;
    } assignment_t;
endpackage

// File: rtl/mca_stream_if.sv
// Valid/ready channel carrying a payload type.
`timescale 1ns / 1ps

interface mca_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/min_cost_assignment_solver.sv
// Top level of the min-cost assignment solver (Hungarian method).
`timescale 1ns / 1ps

// Loads an n-by-n cost matrix one item per cycle in row-major order
// (n from cfg_wdata, written with cfg_we; 0 acts as 1, above MAX_N acts
// as MAX_N). After the last entry it solves with the potential/slack
// Hungarian method on one shared datapath: a search step reads the entry
// of each unvisited column and then folds it into the slack scan, passes
// over each visited column, then updates the potentials of columns 0..n
// in turn. Row i takes one to i search steps; after the last row the
// total cost is added up. It then emits n results, one per cycle when
// taken, and only then accepts the next matrix.
module min_cost_assignment_solver
    import mca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [SIZE_WIDTH-1:0] cfg_wdata,
    mca_stream_if.sink   cost_in,
    mca_stream_if.source result_out
);
    localparam int NW = $clog2(MAX_N + 1);
    localparam int AW = $clog2(MAX_N * MAX_N);
    localparam int CW = $clog2(MAX_N * MAX_N + 1);
    localparam int VW = COST_WIDTH + NW + 4;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_BACK = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic signed [COST_WIDTH-1:0] mem [MAX_N*MAX_N];
    logic signed [COST_WIDTH-1:0] rd_reg;
    logic signed [VW-1:0] u_reg [MAX_N+1];
    logic signed [VW-1:0] v_reg [MAX_N+1];
    logic signed [VW-1:0] slack_reg [MAX_N+1];
    logic [NW-1:0] match_reg [MAX_N+1];
    logic [NW-1:0] way_reg [MAX_N+1];
    logic [MAX_N:0] used_reg;
    logic [SIZE_WIDTH-1:0] size_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0] st_reg;
    logic [NW-1:0] i_reg, j_reg, j0_reg, j1_reg, i0_reg;
    logic signed [VW-1:0] delta_reg, sum_reg;
    logic phase_reg;
    logic [IDX_WIDTH-1:0] task_reg [MAX_N];

    logic [NW-1:0] n;
    logic [AW-1:0] addr;
    logic signed [VW-1:0] cur, sl;
    logic [CW-1:0] total;

    always_comb
    begin
        if (size_reg == '0)
            n = NW'(1);
        else if (32'(size_reg) > MAX_N)
            n = NW'(MAX_N);
        else
            n = NW'(size_reg);
        total = CW'(n) * CW'(n);
    end

    // read address: sum entry in the sum state, else scan entry
    always_comb
    begin
        if (st_reg == S_SUM)
            addr = AW'(32'(j_reg) * 32'(n) + 32'(task_reg[j_reg[IDX_WIDTH-1:0]]));
        else
            addr = AW'(32'(i0_reg - NW'(1)) * 32'(n) + 32'(j_reg - NW'(1)));
    end

    always_ff @(posedge clk)
    begin
        if (cost_in.valid && cost_in.ready && 32'(cnt_reg) < MAX_N * MAX_N)
            mem[cnt_reg[AW-1:0]] <= cost_in.data.cost_value;
        rd_reg <= mem[addr];
    end

    assign cur = VW'(rd_reg) - u_reg[i0_reg] - v_reg[j_reg];
    assign sl = (cur < slack_reg[j_reg]) ? cur : slack_reg[j_reg];

    assign cost_in.ready = (st_reg == S_LOAD);
    assign result_out.valid = (st_reg == S_OUT);
    assign result_out.data.agent_index = j_reg[IDX_WIDTH-1:0];
    assign result_out.data.assigned_task = task_reg[j_reg[IDX_WIDTH-1:0]];
    assign result_out.data.total_cost = sum_reg[TOTAL_WIDTH-1:0];
    assign result_out.data.last_result = (j_reg + NW'(1) == n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD;
            cnt_reg <= '0;
            size_reg <= SIZE_WIDTH'(16);
            phase_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
                cnt_reg <= '0;
            end
            case (st_reg)
                S_LOAD:
                begin
                    if (cost_in.valid && !cfg_we)
                    begin
                        if (cnt_reg + CW'(1) >= total)
                        begin
                            cnt_reg <= '0;
                            st_reg <= S_ROW;
                            i_reg <= NW'(1);
                            for (int k = 0; k <= MAX_N; k++)
                            begin
                                u_reg[k] <= '0;
                                v_reg[k] <= '0;
                                match_reg[k] <= '0;
                                way_reg[k] <= '0;
                            end
                        end
                        else
                            cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_ROW:
                begin
                    // new row: mark column 0, reset slack
                    match_reg[0] <= i_reg;
                    i0_reg <= i_reg;
                    j0_reg <= '0;
                    used_reg <= (MAX_N+1)'(1);
                    for (int k = 0; k <= MAX_N; k++)
                        slack_reg[k] <= {1'b0, {(VW-1){1'b1}}};
                    delta_reg <= {1'b0, {(VW-1){1'b1}}};
                    j1_reg <= '0;
                    j_reg <= NW'(1);
                    phase_reg <= 1'b0;
                    st_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // phase 0 reads the entry, phase 1 folds it in
                    if (!phase_reg && !used_reg[j_reg])
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (phase_reg)
                        begin
                            if (cur < slack_reg[j_reg])
                            begin
                                slack_reg[j_reg] <= cur;
                                way_reg[j_reg] <= j0_reg;
                            end
                            if (sl < delta_reg)
                            begin
                                delta_reg <= sl;
                                j1_reg <= j_reg;
                            end
                        end
                        if (j_reg == n)
                        begin
                            j_reg <= '0;
                            st_reg <= S_UPD;
                        end
                        else
                            j_reg <= j_reg + NW'(1);
                    end
                end
                S_UPD:
                begin
                    if (used_reg[j_reg])
                    begin
                        u_reg[match_reg[j_reg]] <= u_reg[match_reg[j_reg]] + delta_reg;
                        v_reg[j_reg] <= v_reg[j_reg] - delta_reg;
                    end
                    else
                        slack_reg[j_reg] <= slack_reg[j_reg] - delta_reg;
                    if (j_reg == n)
                    begin
                        j0_reg <= j1_reg;
                        if (j1_reg != '0 && match_reg[j1_reg] != '0)
                        begin
                            used_reg[j1_reg] <= 1'b1;
                            i0_reg <= match_reg[j1_reg];
                            delta_reg <= {1'b0, {(VW-1){1'b1}}};
                            j1_reg <= '0;
                            j_reg <= NW'(1);
                            st_reg <= S_SCAN;
                        end
                        else
                            st_reg <= S_BACK;
                    end
                    else
                        j_reg <= j_reg + NW'(1);
                end
                S_BACK:
                begin
                    if (j0_reg != '0)
                    begin
                        match_reg[j0_reg] <= match_reg[way_reg[j0_reg]];
                        j0_reg <= way_reg[j0_reg];
                    end
                    else if (i_reg == n)
                    begin
                        for (int k = 1; k <= MAX_N; k++)
                            if (match_reg[k] != '0 && 32'(k) <= 32'(n))
                                task_reg[IDX_WIDTH'(match_reg[k] - NW'(1))] <=
                                    IDX_WIDTH'(k - 1);
                        j_reg <= '0;
                        sum_reg <= '0;
                        phase_reg <= 1'b0;
                        st_reg <= S_SUM;
                    end
                    else
                    begin
                        i_reg <= i_reg + NW'(1);
                        st_reg <= S_ROW;
                    end
                end
                S_SUM:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        sum_reg <= sum_reg + VW'(rd_reg);
                        if (j_reg + NW'(1) == n)
                        begin
                            j_reg <= '0;
                            st_reg <= S_OUT;
                        end
                        else
                            j_reg <= j_reg + NW'(1);
                    end
                end
                S_OUT:
                begin
                    if (result_out.ready)
                    begin
                        if (j_reg + NW'(1) == n)
                            st_reg <= S_LOAD;
                        else
                            j_reg <= j_reg + NW'(1);
                    end
                end
                default:
                    st_reg <= S_LOAD;
            endcase
        end
    end
endmodule

// File: bench/tb_top.sv
// Self-checking bench for the min-cost assignment solver: loads matrices, predicts results.
`timescale 1ns / 1ps

module tb_top;
    import mca_pkg::*;

    localparam longint SLACK_MAX = 64'sd1 <<< 60;

    // cost patterns: full range, tiny values (many ties), extremes only
    localparam int STYLE_FULL    = 0;
    localparam int STYLE_TINY    = 1;
    localparam int STYLE_EXTREME = 2;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SIZE_WIDTH-1:0] cfg_wdata;

    mca_stream_if #(.payload_t(cost_item_t))  cost_if ();
    mca_stream_if #(.payload_t(assignment_t)) result_if ();

    min_cost_assignment_solver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cost_in    (cost_if),
        .result_out (result_if)
    );

    // predictor state
    logic signed [15:0]    cost_mem [0:MAX_N*MAX_N-1];
    int                    entries_loaded;
    logic [SIZE_WIDTH-1:0] size_reg;
    longint                row_pot [0:MAX_N];
    longint                col_pot [0:MAX_N];
    longint                slack [0:MAX_N];
    int                    col_owner [0:MAX_N];
    int                    came_from [0:MAX_N];
    bit                    visited [0:MAX_N];

    cost_item_t  pending_costs [$];
    assignment_t expected_assignments [$];
    bit          in_fire;
    bit          failed;
    int          send_gap;
    int          stall_left;
    bit          no_stall_run;
    int          items_sent;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int active_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_N)
            return MAX_N;
        return int'(size_reg);
    endfunction

    function automatic longint cost_at(int n, int r, int c);
        return longint'(cost_mem[r * n + c]);
    endfunction

    function automatic void solve_assignment(int n);
        int     task_of [0:MAX_N-1];
        int     j0;
        int     j1;
        int     i0;
        longint delta;
        longint cur;
        longint sum;
        assignment_t res;
        for (int j = 0; j <= MAX_N; j++)
        begin
            row_pot[j] = 0;
            col_pot[j] = 0;
            col_owner[j] = 0;
            came_from[j] = 0;
        end
        for (int i = 1; i <= n; i++)
        begin
            j0 = 0;
            col_owner[0] = i;
            for (int j = 0; j <= n; j++)
            begin
                slack[j] = SLACK_MAX;
                visited[j] = 1'b0;
            end
            do
            begin
                visited[j0] = 1'b1;
                i0 = col_owner[j0];
                delta = SLACK_MAX;
                j1 = 0;
                for (int j = 1; j <= n; j++)
                begin
                    if (!visited[j])
                    begin
                        cur = cost_at(n, i0 - 1, j - 1) - row_pot[i0] - col_pot[j];
                        if (cur < slack[j])
                        begin
                            slack[j] = cur;
                            came_from[j] = j0;
                        end
                        if (slack[j] < delta)
                        begin
                            delta = slack[j];
                            j1 = j;
                        end
                    end
                end
                for (int j = 0; j <= n; j++)
                begin
                    if (visited[j])
                    begin
                        row_pot[col_owner[j]] += delta;
                        col_pot[j] -= delta;
                    end
                    else
                        slack[j] -= delta;
                end
                j0 = j1;
            end while (j0 != 0 && col_owner[j0] != 0);
            // augment back along the path
            while (j0 != 0)
            begin
                j1 = came_from[j0];
                col_owner[j0] = col_owner[j1];
                j0 = j1;
            end
        end
        for (int i = 0; i < n; i++)
            task_of[i] = 0;
        for (int j = 1; j <= n; j++)
            if (col_owner[j] >= 1 && col_owner[j] <= n)
                task_of[col_owner[j] - 1] = j - 1;
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += cost_at(n, i, task_of[i]);
        for (int i = 0; i < n; i++)
        begin
            res.agent_index   = i[IDX_WIDTH-1:0];
            res.assigned_task = task_of[i][IDX_WIDTH-1:0];
            res.total_cost    = sum[TOTAL_WIDTH-1:0];
            res.last_result   = (i == n - 1);
            expected_assignments = {expected_assignments, res};
        end
    endfunction

    function automatic void load_cost(logic signed [15:0] value);
        int n;
        n = active_size();
        if (entries_loaded < MAX_N * MAX_N)
            cost_mem[entries_loaded] = value;
        entries_loaded++;
        if (entries_loaded >= n * n)
        begin
            entries_loaded = 0;
            solve_assignment(n);
        end
    endfunction

    // acceptance on both channels and checking
    always @(posedge clk)
    begin
        assignment_t want;
        assignment_t got;
        in_fire <= cost_if.valid && cost_if.ready;
        if (rst_n && cost_if.valid && cost_if.ready)
            load_cost(cost_if.data.cost_value);
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (expected_assignments.size() == 0)
            begin
                $error("unexpected result: agent_index %0d", got.agent_index);
                failed = 1'b1;
            end
            else
            begin
                want = expected_assignments.pop_front();
                if (got.agent_index !== want.agent_index)
                begin
                    $error("agent_index: expected %0d, got %0d", want.agent_index,
                           got.agent_index);
                    failed = 1'b1;
                end
                if (got.assigned_task !== want.assigned_task)
                begin
                    $error("assigned_task: expected %0d, got %0d", want.assigned_task,
                           got.assigned_task);
                    failed = 1'b1;
                end
                if (got.total_cost !== want.total_cost)
                begin
                    $error("total_cost: expected %0d, got %0d", want.total_cost,
                           got.total_cost);
                    failed = 1'b1;
                end
                if (got.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d", want.last_result,
                           got.last_result);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        if (no_stall_run)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // cost driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cost_if.valid && !in_fire)
                ;
            else if (send_gap > 0)
            begin
                cost_if.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_costs.size() > 0)
            begin
                cost_if.data  <= pending_costs.pop_front();
                cost_if.valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                cost_if.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 199) == 0)
                no_stall_run = !no_stall_run;
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic wait_idle();
        while (pending_costs.size() != 0 || cost_if.valid || expected_assignments.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_size(logic [SIZE_WIDTH-1:0] value);
        wait_idle();
        repeat (20) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        size_reg = value;
        entries_loaded = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_costs(int count, int style);
        cost_item_t item;
        for (int k = 0; k < count; k++)
        begin
            case (style)
                STYLE_FULL: item.cost_value = 16'($urandom_range(0, 65535));
                STYLE_TINY: item.cost_value = 16'($urandom_range(0, 3));
                default: item.cost_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            endcase
            pending_costs = {pending_costs, item};
            items_sent++;
        end
    endtask

    task automatic queue_value(logic signed [15:0] value);
        cost_item_t item;
        item.cost_value = value;
        pending_costs = {pending_costs, item};
        items_sent++;
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cost_if.valid = 1'b0;
        cost_if.data = '0;
        result_if.ready = 1'b0;
        in_fire = 1'b0;
        failed = 1'b0;
        send_gap = 0;
        stall_left = 0;
        no_stall_run = 1'b0;
        items_sent = 0;
        entries_loaded = 0;
        size_reg = 5'd16;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_size(5'd1);
        queue_value(16'sh8000);
        queue_value(16'sh7fff);
        write_size(5'd2);
        queue_value(16'sh7fff);
        queue_value(16'sh8000);
        queue_value(16'sh8000);
        queue_value(16'sh7fff);
        queue_costs(4, STYLE_TINY);
        // zero acts as one
        write_size(5'd0);
        queue_value(-16'sd5);
        // rewrite mid-load restarts at the first entry
        write_size(5'd3);
        queue_costs(4, STYLE_FULL);
        write_size(5'd3);
        queue_costs(9, STYLE_EXTREME);
        // above the maximum acts as sixteen
        write_size(5'd31);
        queue_costs(MAX_N * MAX_N, STYLE_FULL);

        while (items_sent < 300)
        begin
            n = $urandom_range(2, 5);
            write_size(n[SIZE_WIDTH-1:0]);
            repeat ($urandom_range(1, 2))
                queue_costs(n * n, $urandom_range(0, 9) < 6 ? STYLE_FULL :
                                   ($urandom_range(0, 1) ? STYLE_TINY : STYLE_EXTREME));
        end

        wait_idle();
        repeat (200) @(negedge clk);
        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/mca_pkg.sv
rtl/mca_stream_if.sv
rtl/min_cost_assignment_solver.sv
bench/tb_top.sv
